// ===== hw/rtl/mlfd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and key helper for the MAC learning forward decision block.
package mlfd_pkg;

	localparam int MAC_W         = 48;
	localparam int VLAN_W        = 12;
	localparam int KEY_W         = 1 + VLAN_W + MAC_W;
	localparam int IN_PORT_W     = 8;
	localparam int PORT_MAX_BITS = 32;
	localparam int IDX_MAX_BITS  = 10;
	localparam int MCAST_BIT     = 40;
	localparam int CFG_IDX_W     = 1;

	localparam logic [MAC_W-1:0] RESERVED_A_RESET = 48'h0180_C200_0000;
	localparam logic [MAC_W-1:0] RESERVED_B_RESET = 48'h0100_5E00_00FB;

	localparam logic [CFG_IDX_W-1:0] REG_RESERVED_A = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_RESERVED_B = 1'b1;

	typedef enum logic [2:0] {
		ACT_DROP    = 3'd0,
		ACT_BLOCK   = 3'd1,
		ACT_FLOOD   = 3'd2,
		ACT_FILTER  = 3'd3,
		ACT_FORWARD = 3'd4
	} action_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SEARCH,
		S_FINISH
	} state_t;

	// Search wave handed from cell to cell; ports are zero-extended to the maximum width.
	typedef struct packed {
		logic                     tok;
		logic                     dst_hit;
		logic [PORT_MAX_BITS-1:0] dst_port;
		logic                     src_hit;
		logic [IDX_MAX_BITS-1:0]  src_idx;
	} wave_t;

	typedef struct packed {
		logic [KEY_W-1:0] dst_key;
		logic [KEY_W-1:0] src_key;
	} query_t;

	typedef struct packed {
		logic                     en;
		logic                     new_entry;
		logic [IDX_MAX_BITS-1:0]  idx;
		logic [KEY_W-1:0]         key;
		logic [PORT_MAX_BITS-1:0] port;
	} wr_t;

	// Untagged frames get tag bit and VLAN zero, distinct from any tagged VLAN.
	function automatic logic [KEY_W-1:0] mk_key(input logic tag_en,
		input logic [VLAN_W-1:0] vlan, input logic [MAC_W-1:0] mac);
		logic [KEY_W-1:0] k;
		if (tag_en) begin
			k = {1'b1, vlan, mac};
		end else begin
			k = {1'b0, {VLAN_W{1'b0}}, mac};
		end
		return k;
	endfunction

endpackage

// ===== hw/rtl/mlfd_ifs.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces: frame header in, decision out, register writes.
interface mlfd_frame_if;
	logic        valid;
	logic        ready;
	logic [47:0] src_mac;
	logic [47:0] dst_mac;
	logic        has_vlan;
	logic [11:0] vlan_tag;
	logic [7:0]  ingress_port;
	modport source(output valid, src_mac, dst_mac, has_vlan, vlan_tag, ingress_port,
		input ready);
	modport sink(input valid, src_mac, dst_mac, has_vlan, vlan_tag, ingress_port,
		output ready);
endinterface

interface mlfd_decision_if;
	logic       valid;
	logic       ready;
	logic [2:0] action;
	logic [7:0] egress_port;
	logic       learn_failed;
	modport source(output valid, action, egress_port, learn_failed, input ready);
	modport sink(input valid, action, egress_port, learn_failed, output ready);
endinterface

interface mlfd_cfg_if;
	logic        valid;
	logic        ready;
	logic [0:0]  index;
	logic [47:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== hw/rtl/mlfd_cell.sv =====
`timescale 1ns / 1ps
// One table entry: holds a key and port, matches the passing search wave.
module mlfd_cell
	import mlfd_pkg::*;
#(
	parameter int PORT_BITS = 8,
	parameter int CELL_IDX  = 0
) (
	input  logic   clk,
	input  logic   arst_n,
	input  query_t qry,
	input  wr_t    wr,
	input  wave_t  wave_in,
	output wave_t  wave_out
);

	localparam logic [IDX_MAX_BITS-1:0] MY_IDX = IDX_MAX_BITS'(CELL_IDX);

	logic                     vld_q;
	logic [KEY_W-1:0]         key_q;
	logic [PORT_BITS-1:0]     port_q;
	logic                     tok_q;
	logic                     dst_hit_q;
	logic [PORT_MAX_BITS-1:0] dst_port_q;
	logic                     src_hit_q;
	logic [IDX_MAX_BITS-1:0]  src_idx_q;
	logic                     dst_match;
	logic                     src_match;
	logic                     wr_here;

	assign dst_match = vld_q && (key_q == qry.dst_key);
	assign src_match = vld_q && (key_q == qry.src_key);
	assign wr_here   = wr.en && (wr.idx == MY_IDX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			tok_q <= 1'b0;
		end else begin
			tok_q <= wave_in.tok;
			if (wr_here && wr.new_entry) begin
				vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_here) begin
			port_q <= wr.port[PORT_BITS-1:0];
			if (wr.new_entry) begin
				key_q <= wr.key;
			end
		end
		// keys are unique, so at most one cell along the row claims each hit
		dst_hit_q  <= wave_in.dst_hit | dst_match;
		dst_port_q <= dst_match ? PORT_MAX_BITS'(port_q) : wave_in.dst_port;
		src_hit_q  <= wave_in.src_hit | src_match;
		src_idx_q  <= src_match ? MY_IDX : wave_in.src_idx;
	end

	always_comb begin
		wave_out.tok      = tok_q;
		wave_out.dst_hit  = dst_hit_q;
		wave_out.dst_port = dst_port_q;
		wave_out.src_hit  = src_hit_q;
		wave_out.src_idx  = src_idx_q;
	end

endmodule

// ===== hw/rtl/mac_learning_forward_decision_unit.sv =====
`timescale 1ns / 1ps
// Learning bridge forwarding decision: one decision word per frame header word.
//
// Channels: frame (sink) takes a header word with source and destination MAC,
// optional VLAN and ingress port; decision (source) returns one word with the
// action, the learned egress port and a learn-failed flag; cfg (sink) writes
// the two reserved destination addresses (index 0 and 1) and is always ready.
// The user must see that cfg is written only while no frame is in flight;
// the block itself does not enforce this.
// The table is a row of TABLE_ENTRIES cells. A search wave enters the first
// cell in the cycle after a header is accepted and moves one cell per cycle,
// collecting the destination hit and the source hit; the learn write, if
// made, then goes to one cell in a single cycle.
// One frame is handled at a time: a new header is taken only after the
// decision for the last one has been issued. Dropped and blocked frames skip
// the search.
// Reset empties the table and restores both reserved addresses.
// A stalled decision word is held in the output register; the block goes on
// searching the next frame and waits before the finish step until it drains.
module mac_learning_forward_decision_unit
	import mlfd_pkg::*;
#(
	parameter int TABLE_ENTRIES = 64,
	parameter int PORT_BITS     = 8
) (
	input logic             clk,
	input logic             arst_n,
	mlfd_frame_if.sink      frame,
	mlfd_decision_if.source decision,
	mlfd_cfg_if.sink        cfg
);

	localparam int UC_W = $clog2(TABLE_ENTRIES + 1);
	localparam logic [UC_W-1:0] FULL_COUNT = UC_W'(TABLE_ENTRIES);

	state_t                   state_q, state_d;
	logic [MAC_W-1:0]         resa_q, resb_q;
	query_t                   qry_q;
	logic [PORT_BITS-1:0]     qport_q;
	logic                     drop_q, block_q, dmc_q;
	logic                     launch_q;
	wave_t                    fin_q;
	logic [UC_W-1:0]          used_q;
	logic                     out_vld_q;
	action_t                  out_act_q;
	logic [IN_PORT_W-1:0]     out_egress_q;
	logic                     out_failed_q;

	wave_t                    wave [TABLE_ENTRIES+1];
	wr_t                      wr;
	logic                     accept;
	logic                     in_drop, in_block;
	logic                     fire;
	logic                     dst_found;
	logic                     learn;
	logic                     table_full;
	action_t                  act;
	logic [PORT_MAX_BITS-1:0] in_port_ext;

	assign frame.ready = (state_q == S_IDLE);
	assign accept      = frame.valid && frame.ready;
	assign cfg.ready   = 1'b1;
	assign in_drop     = frame.src_mac[MCAST_BIT];
	assign in_block    = (frame.dst_mac == resa_q) || (frame.dst_mac == resb_q);
	assign in_port_ext = PORT_MAX_BITS'(frame.ingress_port);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resa_q <= RESERVED_A_RESET;
			resb_q <= RESERVED_B_RESET;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_RESERVED_A: resa_q <= cfg.data;
				REG_RESERVED_B: resb_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// query capture
	always_ff @(posedge clk) begin
		if (accept) begin
			qry_q.dst_key <= mk_key(frame.has_vlan, frame.vlan_tag, frame.dst_mac);
			qry_q.src_key <= mk_key(frame.has_vlan, frame.vlan_tag, frame.src_mac);
			qport_q       <= in_port_ext[PORT_BITS-1:0];
			drop_q        <= in_drop;
			block_q       <= in_block;
			dmc_q         <= frame.dst_mac[MCAST_BIT];
		end
		if (state_q == S_SEARCH && wave[TABLE_ENTRIES].tok) begin
			fin_q <= wave[TABLE_ENTRIES];
		end
	end

	always_comb begin
		wave[0]     = '0;
		wave[0].tok = launch_q;
	end

	for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
		mlfd_cell #(
			.PORT_BITS(PORT_BITS),
			.CELL_IDX (i)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.qry     (qry_q),
			.wr      (wr),
			.wave_in (wave[i]),
			.wave_out(wave[i+1])
		);
	end

	// decision and learn write
	assign fire       = (state_q == S_FINISH) && (!out_vld_q || decision.ready);
	assign dst_found  = fin_q.dst_hit && !dmc_q;
	assign table_full = (used_q == FULL_COUNT);

	always_comb begin
		priority if (drop_q) begin
			act = ACT_DROP;
		end else if (block_q) begin
			act = ACT_BLOCK;
		end else if (!dst_found) begin
			act = ACT_FLOOD;
		end else if (fin_q.dst_port[PORT_BITS-1:0] == qport_q) begin
			act = ACT_FILTER;
		end else begin
			act = ACT_FORWARD;
		end
	end

	assign learn = (act == ACT_FLOOD) || (act == ACT_FORWARD);

	always_comb begin
		wr.en        = fire && learn && (fin_q.src_hit || !table_full);
		wr.new_entry = !fin_q.src_hit;
		wr.idx       = fin_q.src_hit ? fin_q.src_idx : IDX_MAX_BITS'(used_q);
		wr.key       = qry_q.src_key;
		wr.port      = PORT_MAX_BITS'(qport_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			launch_q  <= 1'b0;
			used_q    <= '0;
			out_vld_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			launch_q <= accept && !in_drop && !in_block;
			if (wr.en && wr.new_entry) begin
				used_q <= used_q + UC_W'(1);
			end
			if (fire) begin
				out_vld_q <= 1'b1;
			end else if (decision.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_act_q    <= act;
			out_egress_q <= (act == ACT_FORWARD) ? fin_q.dst_port[IN_PORT_W-1:0] : '0;
			out_failed_q <= learn && !fin_q.src_hit && table_full;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = (in_drop || in_block) ? S_FINISH : S_SEARCH;
				end
			end
			S_SEARCH: begin
				if (wave[TABLE_ENTRIES].tok) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				if (fire) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign decision.valid        = out_vld_q;
	assign decision.action       = out_act_q;
	assign decision.egress_port  = out_egress_q;
	assign decision.learn_failed = out_failed_q;

`ifndef SYNTH
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= FULL_COUNT)
		else $error("entry count beyond table size");

	a_fail_full: assert property (@(posedge clk) disable iff (!arst_n)
		decision.valid && decision.learn_failed |-> used_q == FULL_COUNT)
		else $error("learn failure reported with free entries");

	a_wave_exit: assert property (@(posedge clk) disable iff (!arst_n)
		wave[TABLE_ENTRIES].tok |-> state_q == S_SEARCH)
		else $error("search wave left the row outside a search");

	a_out_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> $past(state_q == S_FINISH))
		else $error("decision word raised outside the finish step");
`endif

endmodule
